>>> src/tbpg_pkg.sv
// ----------------------------------------------------------------------------
// tbpg_pkg
// Shared constants, types and color helpers for the text/bitmap pixel
// generator.
// ----------------------------------------------------------------------------
package tbpg_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int TEXT_COLUMNS  = 80;
  localparam int GLYPH_COUNT   = 256;

  localparam int VRAM_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int GRAM_BYTES = GLYPH_COUNT * 8;
  localparam int VA_W       = $clog2(VRAM_BYTES);
  localparam int GA_W       = $clog2(GRAM_BYTES);
  localparam int CELL_W     = $clog2((SCREEN_WIDTH / 8) * ((SCREEN_HEIGHT + 7) / 8) + 1);

  localparam logic [7:0] IRGB_FULL   = 8'hAA;
  localparam logic [7:0] IRGB_BRIGHT = 8'h55;
  localparam logic [23:0] WHITE      = 24'hFFFFFF;
  localparam logic [23:0] BLACK      = 24'h000000;

  localparam int TOP_LEN    = 14;
  localparam int BOTTOM_LEN = 29;
  localparam int TOP_IW     = $clog2(TOP_LEN);
  localparam int BOTTOM_IW  = $clog2(BOTTOM_LEN);

  // "UNDEFINED MODE"
  localparam logic [7:0] TOP_BANNER [TOP_LEN] = '{
    8'h55, 8'h4E, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4E, 8'h45, 8'h44, 8'h20,
    8'h4D, 8'h4F, 8'h44, 8'h45
  };

  // version banner
  localparam logic [7:0] BOTTOM_BANNER [BOTTOM_LEN] = '{
    8'h4F, 8'h70, 8'h65, 8'h6E, 8'h20, 8'h47, 8'h72, 8'h61, 8'h70, 8'h68,
    8'h69, 8'h63, 8'h73, 8'h20, 8'h41, 8'h72, 8'h72, 8'h61, 8'h79, 8'h20,
    8'h30, 8'h2E, 8'h31, 8'h2E, 8'h30, 8'h2D, 8'h72, 8'h63, 8'h31
  };

  typedef enum logic [1:0] {
    OP_VWRITE = 2'd0,
    OP_GWRITE = 2'd1,
    OP_FETCH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [7:0] MODE_TEXT   = 8'd0;
  localparam logic [7:0] MODE_BITMAP = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHAR,
    S_ATTR,
    S_BMP,
    S_BAN,
    S_DONE
  } state_e;

  function automatic logic [23:0] expand332(input logic [7:0] c);
    logic [2:0] r;
    logic [2:0] g;
    logic [1:0] b;
    r = c[7:5];
    g = c[4:2];
    b = c[1:0];
    return {r, r, r[2:1], g, g, g[2:1], b, b, b, b};
  endfunction

  function automatic logic [23:0] irgb_to_rgb888(input logic [3:0] i);
    logic [7:0] hi;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    hi = i[3] ? IRGB_BRIGHT : 8'h00;
    r  = (i[2] ? IRGB_FULL : 8'h00) | hi;
    g  = (i[1] ? IRGB_FULL : 8'h00) | hi;
    b  = (i[0] ? IRGB_FULL : 8'h00) | hi;
    return expand332({r[7:5], g[7:5], b[7:6]});
  endfunction

endpackage

>>> src/tbpg_ram.sv
// ----------------------------------------------------------------------------
// tbpg_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tbpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> src/text_bitmap_pixel_generator.sv
// ----------------------------------------------------------------------------
// text_bitmap_pixel_generator
// Pixel generator with a byte-writable video RAM and glyph RAM, giving one
// RGB888 color per pixel fetch in text, bitmap or undefined-mode display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per operation:
//   a video RAM byte write, a glyph RAM byte write or a pixel fetch. Writes
//   produce no output word; each fetch produces one pixel_color_o word on
//   the output channel (out_valid_o / out_stall_i).
//   The cfg channel (cfg_valid_i / cfg_ready_o) writes display_mode; it is
//   always ready and is meant to be written while the block is idle.
//   A write is taken in the idle state. A fetch passes S_LOOK, then S_CHAR
//   and S_ATTR in text mode, S_BMP in bitmap mode or S_BAN on a banner
//   character, and goes straight to S_DONE for an off-screen or plain black
//   pixel; from S_DONE the result is loaded into the output register. The
//   steps are set by the dependent reads through the single read port of
//   each RAM: character, then attribute alongside the glyph row.
//   One item is processed at a time; the input stalls until it completes.
//   A finished result waits in the output register while out_stall_i is
//   high, and the next item is still accepted; a second result waits
//   internally until the register frees up.
//   Reset clears control state and sets display_mode to text; RAM contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module text_bitmap_pixel_generator
  import tbpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [18:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [9:0]  column_i,
  input  logic [8:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] pixel_color_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [7:0]  mode_q;
  logic        out_valid_q, out_valid_d;
  logic [23:0] pixel_q;
  logic [23:0] res_q, res_d;
  logic [9:0]  x_q;
  logic [8:0]  y_q;
  logic [VA_W-1:0] taddr_q, taddr_d;
  logic        attr_ok_q, attr_ok_d;
  logic        gl_ok_q, gl_ok_d;

  logic            vram_we, vram_re;
  logic [VA_W-1:0] vram_raddr;
  logic [7:0]      vram_rdata;
  logic            gram_we, gram_re;
  logic [GA_W-1:0] gram_raddr;
  logic [7:0]      gram_rdata;

  logic accept, load;

  logic [CELL_W-1:0] cell_idx;
  logic [VA_W:0]     cell_byte;
  logic [6:0]        bcell;
  logic [8:0]        bot_dy;
  logic [7:0]        ch;
  logic              glyph_bit;
  logic [3:0]        nib;
  logic [7:0]        attr;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign load        = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load || (out_valid_q && out_stall_i);
  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = pixel_q;

  assign vram_we = accept && (op_i == OP_VWRITE) && (address_i < 19'(VRAM_BYTES));
  assign gram_we = accept && (op_i == OP_GWRITE) && (address_i < 19'(GRAM_BYTES));

  assign cell_idx  = CELL_W'(y_q[8:3]) * CELL_W'(TEXT_COLUMNS) + CELL_W'(x_q[9:3]);
  assign cell_byte = {(VA_W + 1 - CELL_W)'(0), cell_idx} << 1;
  assign bcell     = x_q[9:3];
  assign bot_dy    = y_q - 9'(SCREEN_HEIGHT - 8);
  assign glyph_bit = gl_ok_q && gram_rdata[3'd7 - x_q[2:0]];
  assign attr      = attr_ok_q ? vram_rdata : 8'h00;
  assign nib       = glyph_bit ? attr[3:0] : attr[7:4];

  tbpg_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_BYTES)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (address_i[VA_W-1:0]),
    .wdata_i (data_i),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  tbpg_ram #(
    .WIDTH (8),
    .DEPTH (GRAM_BYTES)
  ) u_gram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .waddr_i (address_i[GA_W-1:0]),
    .wdata_i (data_i),
    .re_i    (gram_re),
    .raddr_i (gram_raddr),
    .rdata_o (gram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_TEXT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= column_i;
      y_q <= row_i;
    end
    if (load) begin
      pixel_q <= res_q;
    end
    res_q     <= res_d;
    taddr_q   <= taddr_d;
    attr_ok_q <= attr_ok_d;
    gl_ok_q   <= gl_ok_d;
  end

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    taddr_d    = taddr_q;
    attr_ok_d  = attr_ok_q;
    gl_ok_d    = gl_ok_q;
    vram_re    = 1'b0;
    vram_raddr = taddr_q;
    gram_re    = 1'b0;
    gram_raddr = '0;
    ch         = 8'h00;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_FETCH)) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        res_d = BLACK;
        if (x_q >= 10'(SCREEN_WIDTH) || y_q >= 9'(SCREEN_HEIGHT)) begin
          state_d = S_DONE;
        end else if (mode_q == MODE_TEXT) begin
          // character byte first, attribute byte right after it
          taddr_d    = VA_W'(cell_byte);
          vram_re    = 1'b1;
          vram_raddr = VA_W'(cell_byte);
          attr_ok_d  = (cell_byte + 1'b1) < (VA_W + 1)'(VRAM_BYTES);
          gl_ok_d    = cell_byte < (VA_W + 1)'(VRAM_BYTES);
          state_d    = S_CHAR;
        end else if (mode_q == MODE_BITMAP) begin
          vram_re    = 1'b1;
          vram_raddr = VA_W'(y_q) * VA_W'(SCREEN_WIDTH) + VA_W'(x_q);
          state_d    = S_BMP;
        end else begin
          priority if (y_q >= 9'(SCREEN_HEIGHT - 8)) begin
            if (bcell < 7'(BOTTOM_LEN)) begin
              ch         = BOTTOM_BANNER[bcell[BOTTOM_IW-1:0]];
              gram_re    = 1'b1;
              gram_raddr = GA_W'({ch, bot_dy[2:0]});
              gl_ok_d    = {1'b0, ch} < 9'(GLYPH_COUNT);
              state_d    = S_BAN;
            end else begin
              state_d = S_DONE;
            end
          end else if (y_q < 9'd8) begin
            if (bcell < 7'(TOP_LEN)) begin
              ch         = TOP_BANNER[bcell[TOP_IW-1:0]];
              gram_re    = 1'b1;
              gram_raddr = GA_W'({ch, y_q[2:0]});
              gl_ok_d    = {1'b0, ch} < 9'(GLYPH_COUNT);
              state_d    = S_BAN;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CHAR: begin
        // fetch the attribute and the glyph row in the same cycle
        ch         = gl_ok_q ? vram_rdata : 8'h00;
        vram_re    = 1'b1;
        vram_raddr = taddr_q + 1'b1;
        gram_re    = 1'b1;
        gram_raddr = GA_W'({ch, y_q[2:0]});
        gl_ok_d    = {1'b0, ch} < 9'(GLYPH_COUNT);
        state_d    = S_ATTR;
      end
      S_ATTR: begin
        res_d   = irgb_to_rgb888(nib);
        state_d = S_DONE;
      end
      S_BMP: begin
        res_d   = expand332(vram_rdata);
        state_d = S_DONE;
      end
      S_BAN: begin
        res_d   = glyph_bit ? WHITE : BLACK;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Write port and read port never act in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vram_we && vram_re) && !(gram_we && gram_re))
    else $error("RAM read and write in the same cycle");

  a_fetch_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OP_FETCH) |=> state_q == S_LOOK)
    else $error("accepted fetch did not start");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i != OP_FETCH) |=> state_q == S_IDLE)
    else $error("write or unused op left idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("output word appeared without a finished fetch");

endmodule

>>> verif/tb_text_bitmap_pixel_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_bitmap_pixel_generator
// Self-checking bench for the pixel generator. It keeps shadow copies of the
// video and glyph memories and of display_mode, and predicts the color of
// every fetch in text, bitmap and undefined mode. Writes are issued before
// any fetch that would read a byte not yet written. Directed cases come
// first, then random traffic in several modes with sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb_text_bitmap_pixel_generator;
  import tbpg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int ADDR_TOP       = (1 << 19) - 1;
  localparam int REPORT_CAP     = 40;

  localparam logic [7:0] TOP_MSG [TOP_LEN] = '{
    8'h55, 8'h4E, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4E, 8'h45, 8'h44, 8'h20,
    8'h4D, 8'h4F, 8'h44, 8'h45
  };
  localparam logic [7:0] BOTTOM_MSG [BOTTOM_LEN] = '{
    8'h4F, 8'h70, 8'h65, 8'h6E, 8'h20, 8'h47, 8'h72, 8'h61, 8'h70, 8'h68,
    8'h69, 8'h63, 8'h73, 8'h20, 8'h41, 8'h72, 8'h72, 8'h61, 8'h79, 8'h20,
    8'h30, 8'h2E, 8'h31, 8'h2E, 8'h30, 8'h2D, 8'h72, 8'h63, 8'h31
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [18:0] address_i;
  logic [7:0]  data_i;
  logic [9:0]  column_i;
  logic [8:0]  row_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [23:0] pixel_color_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  // shadow state
  logic [7:0]  vram_copy [VRAM_BYTES];
  bit          vram_set  [VRAM_BYTES];
  logic [7:0]  gram_copy [GRAM_BYTES];
  bit          gram_set  [GRAM_BYTES];
  logic [7:0]  disp_mode;

  logic [23:0] pixel_queue [$];
  logic [23:0] pixel_want;
  int          error_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  text_bitmap_pixel_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .address_i     (address_i),
    .data_i        (data_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [23:0] widen_rgb332(logic [7:0] c);
    int r;
    int g;
    int b;
    r = c[7:5];
    g = c[4:2];
    b = c[1:0];
    r = ((r << 5) | (r << 2) | (r >> 1)) & 8'hFF;
    g = ((g << 5) | (g << 2) | (g >> 1)) & 8'hFF;
    b = (b << 6) | (b << 4) | (b << 2) | b;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [23:0] irgb_color(logic [3:0] nib);
    logic [7:0] bright;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bright = nib[3] ? 8'h55 : 8'h00;
    r = bright | (nib[2] ? 8'hAA : 8'h00);
    g = bright | (nib[1] ? 8'hAA : 8'h00);
    b = bright | (nib[0] ? 8'hAA : 8'h00);
    return widen_rgb332({r[7:5], g[7:5], b[7:6]});
  endfunction

  function automatic bit glyph_lit(logic [7:0] ch, int col, int line);
    logic [7:0] bits;
    bits = gram_copy[ch * 8 + (line % 8)];
    return bits[7 - (col % 8)];
  endfunction

  function automatic logic [23:0] predict_pixel(int col, int row);
    int         cell_idx;
    int         cx;
    logic [7:0] ch;
    logic [7:0] attr;
    if (col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return BLACK;
    if (disp_mode == MODE_TEXT) begin
      cell_idx = (row / 8) * TEXT_COLUMNS + col / 8;
      ch   = vram_copy[cell_idx * 2];
      attr = vram_copy[cell_idx * 2 + 1];
      return irgb_color(glyph_lit(ch, col, row) ? attr[3:0] : attr[7:4]);
    end
    if (disp_mode == MODE_BITMAP) return widen_rgb332(vram_copy[row * SCREEN_WIDTH + col]);
    cx = col / 8;
    if (row >= SCREEN_HEIGHT - 8) begin
      if (cx >= BOTTOM_LEN) return BLACK;
      return glyph_lit(BOTTOM_MSG[cx], col, row - (SCREEN_HEIGHT - 8)) ? WHITE : BLACK;
    end
    if (row < 8 && cx < TOP_LEN) return glyph_lit(TOP_MSG[cx], col, row) ? WHITE : BLACK;
    return BLACK;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    if (error_count < REPORT_CAP)
      $display("mismatch: %s got %06h want %06h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance with
  // valid still high.
  task automatic send_word(op_e op, int addr, int data, int col, int row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    address_i  <= addr[18:0];
    data_i     <= data[7:0];
    column_i   <= col[9:0];
    row_i      <= row[8:0];
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_VWRITE: begin
        if (addr < VRAM_BYTES) begin
          vram_copy[addr] = data[7:0];
          vram_set[addr]  = 1'b1;
        end
      end
      OP_GWRITE: begin
        if (addr < GRAM_BYTES) begin
          gram_copy[addr] = data[7:0];
          gram_set[addr]  = 1'b1;
        end
      end
      OP_FETCH: pixel_queue.push_back(predict_pixel(col, row));
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic prime_video(int addr);
    if (!vram_set[addr])
      send_word(OP_VWRITE, addr, $urandom_range(255), $urandom_range(1023), $urandom_range(511));
  endtask

  task automatic prime_glyph(int addr);
    if (!gram_set[addr])
      send_word(OP_GWRITE, addr, $urandom_range(255), $urandom_range(1023), $urandom_range(511));
  endtask

  // Write every byte the fetch will read that holds no value yet.
  task automatic prime_pixel(int col, int row);
    int cell_idx;
    int cx;
    if (col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return;
    cx = col / 8;
    if (disp_mode == MODE_TEXT) begin
      cell_idx = (row / 8) * TEXT_COLUMNS + cx;
      prime_video(cell_idx * 2);
      prime_video(cell_idx * 2 + 1);
      prime_glyph(vram_copy[cell_idx * 2] * 8 + row % 8);
    end else if (disp_mode == MODE_BITMAP) begin
      prime_video(row * SCREEN_WIDTH + col);
    end else if (row >= SCREEN_HEIGHT - 8) begin
      if (cx < BOTTOM_LEN) prime_glyph(BOTTOM_MSG[cx] * 8 + row - (SCREEN_HEIGHT - 8));
    end else if (row < 8 && cx < TOP_LEN) begin
      prime_glyph(TOP_MSG[cx] * 8 + row);
    end
  endtask

  task automatic fetch_pixel(int col, int row);
    prime_pixel(col, row);
    send_word(OP_FETCH, $urandom_range(ADDR_TOP), $urandom_range(255), col, row);
  endtask

  // Drop valid, drain all pending pixels and let the last write retire.
  task automatic settle();
    in_valid_i     <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pixel_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_mode(logic [7:0] mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    disp_mode = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_text_mode();
    set_mode(MODE_TEXT);
    // cell 0: 'A', bright red on bright blue, glyph row 0 lit at both ends
    send_word(OP_VWRITE, 0, 8'h41, 0, 0);
    send_word(OP_VWRITE, 1, 8'h9C, 0, 0);
    send_word(OP_GWRITE, 8'h41 * 8, 8'h81, 0, 0);
    fetch_pixel(0, 0);
    fetch_pixel(1, 0);
    // last cell: char 255, white on black, last glyph byte
    send_word(OP_VWRITE, VRAM_BYTES / 32 - 2, 8'hFF, 0, 0);
    send_word(OP_VWRITE, 2 * (TEXT_COLUMNS * (SCREEN_HEIGHT / 8)) - 1, 8'h0F, 0, 0);
    send_word(OP_GWRITE, GRAM_BYTES - 1, 8'h01, 0, 0);
    fetch_pixel(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    fetch_pixel(SCREEN_WIDTH - 8, SCREEN_HEIGHT - 1);
    // off-screen fetches, ignored writes and the unused op
    fetch_pixel(SCREEN_WIDTH, 0);
    fetch_pixel(1023, 511);
    send_word(OP_VWRITE, ADDR_TOP, 8'hFF, 0, 0);
    send_word(OP_GWRITE, GRAM_BYTES, 8'hFF, 0, 0);
    send_word(OP_NONE, ADDR_TOP, 8'hFF, 1023, 511);
    settle();
  endtask

  task automatic test_bitmap_mode();
    set_mode(MODE_BITMAP);
    send_word(OP_VWRITE, VRAM_BYTES - 1, 8'hB6, 0, 0);
    fetch_pixel(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    fetch_pixel(0, 0);
    settle();
  endtask

  task automatic test_undefined_mode();
    set_mode(8'hFF);
    fetch_pixel(0, 0);
    fetch_pixel(TOP_LEN * 8 - 1, 7);
    fetch_pixel(TOP_LEN * 8, 0);
    fetch_pixel(BOTTOM_LEN * 8 - 1, SCREEN_HEIGHT - 1);
    fetch_pixel(BOTTOM_LEN * 8, SCREEN_HEIGHT - 1);
    fetch_pixel(0, SCREEN_HEIGHT / 2);
    settle();
  endtask

  task automatic run_traffic(logic [7:0] mode, int send_pct, int stall_pct, int count);
    int done;
    int pick;
    int sel;
    int addr;
    int col;
    int row;
    done = 0;
    set_mode(mode);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        sel = $urandom_range(99);
        if (sel < 15) begin
          col = $urandom_range(1023);
          row = $urandom_range(511);
        end else if (sel < 55) begin
          col = $urandom_range(63);
          row = $urandom_range(31);
        end else begin
          col = $urandom_range(SCREEN_WIDTH - 1);
          row = $urandom_range(SCREEN_HEIGHT - 1);
        end
        // aim half of the undefined-mode fetches at the banner rows
        if (disp_mode != MODE_TEXT && disp_mode != MODE_BITMAP && $urandom_range(1)) begin
          col = $urandom_range(255);
          row = $urandom_range(1) ? $urandom_range(7) : SCREEN_HEIGHT - 8 + $urandom_range(7);
        end
        fetch_pixel(col, row);
        done++;
      end else if (pick < 78) begin
        sel = $urandom_range(99);
        if (sel < 40) addr = $urandom_range(1279);
        else if (sel < 70) addr = $urandom_range(31) * SCREEN_WIDTH + $urandom_range(63);
        else if (sel < 90) addr = $urandom_range(VRAM_BYTES - 1);
        else addr = $urandom_range(ADDR_TOP, VRAM_BYTES);
        send_word(OP_VWRITE, addr, $urandom_range(255), $urandom_range(1023),
                  $urandom_range(511));
        if (addr < VRAM_BYTES) done++;
      end else if (pick < 94) begin
        addr = ($urandom_range(99) < 85) ? $urandom_range(GRAM_BYTES - 1)
                                         : $urandom_range(ADDR_TOP, GRAM_BYTES);
        send_word(OP_GWRITE, addr, $urandom_range(255), $urandom_range(1023),
                  $urandom_range(511));
        if (addr < GRAM_BYTES) done++;
      end else begin
        send_word(OP_NONE, $urandom_range(ADDR_TOP), $urandom_range(255),
                  $urandom_range(1023), $urandom_range(511));
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    run_traffic(MODE_TEXT,   0,  0,  160);
    run_traffic(MODE_BITMAP, 65, 0,  160);
    run_traffic(8'hFF,       0,  65, 160);
    run_traffic(MODE_TEXT,   13, 13, 160);
    run_traffic(MODE_BITMAP, 13, 13, 160);
    run_traffic(8'($urandom_range(254, 2)), 0, 0, 160);
    run_traffic(MODE_TEXT,   0,  65, 160);
    run_traffic(8'd2,        65, 0,  160);
  endtask

  // ---------------------------------------------------------------- checking

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("pixel with no fetch pending", pixel_color_o, BLACK);
      end else begin
        pixel_want = pixel_queue.pop_front();
        if (pixel_color_o !== pixel_want) report_mismatch("pixel_color", pixel_color_o, pixel_want);
      end
    end
  end

  // Count cycles with no word moving on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OP_NONE;
    address_i      = '0;
    data_i         = '0;
    column_i       = '0;
    row_i          = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    disp_mode      = MODE_TEXT;
    error_count    = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_text_mode();
    test_bitmap_mode();
    test_undefined_mode();
    test_random_traffic();

    if (pixel_queue.size() != 0) report_mismatch("fetch left without pixel", BLACK, BLACK);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
